/* rtl/core/att_pkg.sv */
// Package for accel_tilt_angles: widths, CORDIC angle table, limits.
// No dependencies.
package att_pkg;
  localparam int TableLen = 24;
  localparam int DataW = 36;
  localparam int AngW = 26;
  localparam logic signed [AngW-1:0] QuarterTurn = AngW'(90 * 65536);
  localparam logic signed [15:0] PitchLimit = 16'sd11520;
  localparam logic signed [15:0] RollLimit = 16'sd23040;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [AngW-1:0]  ang;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int i);
    logic [22:0] t;
    unique case (i)
      0: t = 23'd2949120; 1: t = 23'd1740967; 2: t = 23'd919879;
      3: t = 23'd466945;  4: t = 23'd234379;  5: t = 23'd117304;
      6: t = 23'd58666;   7: t = 23'd29335;   8: t = 23'd14668;
      9: t = 23'd7334;    10: t = 23'd3667;   11: t = 23'd1833;
      12: t = 23'd917;    13: t = 23'd458;    14: t = 23'd229;
      15: t = 23'd115;    16: t = 23'd57;     17: t = 23'd29;
      18: t = 23'd14;     19: t = 23'd7;      20: t = 23'd4;
      21: t = 23'd2;      22: t = 23'd1;      default: t = 23'd0;
    endcase
    return AngW'(signed'({1'b0, t}));
  endfunction

  function automatic cordic_t cordic_iter(input cordic_t c, input int i);
    cordic_t r;
    logic signed [DataW-1:0] dx;
    logic signed [DataW-1:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.y[DataW-1]) begin
      r.x = c.x + dx; r.y = c.y - dy; r.ang = c.ang + atan_tab(i);
    end else begin
      r.x = c.x - dx; r.y = c.y + dy; r.ang = c.ang - atan_tab(i);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [AngW-1:0] a,
                                               input logic signed [15:0] lim);
    logic signed [AngW-1:0] r;
    r = (a + AngW'(256)) >>> 9;
    if (r > AngW'(lim)) r = AngW'(lim);
    else if (r < -AngW'(lim)) r = -AngW'(lim);
    return r[15:0];
  endfunction
endpackage

/* rtl/core/att_front.sv */
// Front end: accepts samples, classifies zero cases, pre-rotates into right half plane.
// Depends on att_pkg.
module att_front import att_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [15:0]      x_i,
  input  logic signed [15:0]      y_i,
  input  logic signed [15:0]      z_i,
  output logic                    f_valid_o,
  input  logic                    f_ready_i,
  output cordic_t                 f_c_o,
  output logic signed [15:0]      f_x_o,
  output logic                    f_allz_o,
  output logic                    f_yz0_o
);
  logic    valid_q;
  cordic_t c_q;
  logic signed [15:0] x_q;
  logic    allz_q, yz0_q;
  cordic_t c_d;
  logic signed [DataW-1:0] ys, zs;

  assign in_ready_o = !valid_q || f_ready_i;
  assign ys = DataW'(y_i) <<< 14;
  assign zs = DataW'(z_i) <<< 14;

  always_comb begin
    c_d.x = zs; c_d.y = ys; c_d.ang = '0;
    if (z_i[15]) begin
      if (!y_i[15]) begin
        c_d.x = ys; c_d.y = -zs; c_d.ang = QuarterTurn;
      end else begin
        c_d.x = -ys; c_d.y = zs; c_d.ang = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      c_q <= c_d; x_q <= x_i;
      yz0_q <= (y_i == '0) && (z_i == '0);
      allz_q <= (x_i == '0) && (y_i == '0) && (z_i == '0);
    end
  end

  assign f_valid_o = valid_q;
  assign f_c_o = c_q;
  assign f_x_o = x_q;
  assign f_allz_o = allz_q;
  assign f_yz0_o = yz0_q;
endmodule

/* rtl/core/att_back.sv */
// Back end: two unrolled CORDIC vectoring pipelines with gain correction between.
// Depends on att_pkg. Whole pipeline advances when output register is free.
module att_back import att_pkg::*; #(
  parameter int Steps = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                f_valid_i,
  output logic                f_ready_o,
  input  cordic_t             f_c_i,
  input  logic signed [15:0]  f_x_i,
  input  logic                f_allz_i,
  input  logic                f_yz0_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  pitch_o,
  output logic signed [15:0]  roll_o
);
  localparam int N = (Steps > TableLen) ? TableLen : Steps;
  localparam int L = 2 * N + 2;

  logic    v_q  [L+1];
  cordic_t c_q  [L+1];
  logic signed [AngW-1:0] roll_q [L+1];
  logic signed [15:0] x_q [L+1];
  logic    az_q [L+1];
  logic    yz_q [L+1];
  logic signed [DataW+30:0] prod_q;
  logic    adv;

  assign adv = !v_q[L] || out_ready_i;
  assign f_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= L; k++) v_q[k] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= f_valid_i;
      for (int k = 1; k <= L; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= f_c_i; x_q[0] <= f_x_i; az_q[0] <= f_allz_i; yz_q[0] <= f_yz0_i;
      for (int k = 1; k <= L; k++) begin
        x_q[k] <= x_q[k-1]; az_q[k] <= az_q[k-1]; yz_q[k] <= yz_q[k-1];
      end
      for (int k = N + 2; k <= L; k++) roll_q[k] <= roll_q[k-1];
      for (int k = 1; k <= N; k++) c_q[k] <= cordic_iter(c_q[k-1], k - 1);
      // stage N+1: gain multiply, capture roll; first-pass x is below 2^31
      prod_q <= $signed(c_q[N].x[31:0]) * $signed({1'b0, InvGainQ30});
      roll_q[N+1] <= yz_q[N] ? '0 : c_q[N].ang;
      // stage N+2: rounding, second pass setup
      c_q[N+2].x <= yz_q[N+1] ? '0 :
                    DataW'((prod_q + (DataW+31)'(64'sd1 <<< 29)) >>> 30);
      c_q[N+2].y <= DataW'(x_q[N+1]) <<< 14;
      c_q[N+2].ang <= '0;
      for (int k = N + 3; k <= L; k++) c_q[k] <= cordic_iter(c_q[k-1], k - N - 3);
    end
  end

  logic               ov_q;
  logic signed [14:0] p_q;
  logic signed [15:0] r_q;
  logic signed [15:0] pt, rt;
  assign pt = to_out(c_q[L].ang, PitchLimit);
  assign rt = to_out(roll_q[L], RollLimit);
  assign ov_q = v_q[L];
  assign p_q = az_q[L] ? '0 : pt[14:0];
  assign r_q = az_q[L] ? '0 : rt;
  assign out_valid_o = ov_q;
  assign pitch_o = p_q;
  assign roll_o = r_q;
endmodule

/* rtl/core/accel_tilt_angles_core.sv */
// Top level of accel_tilt_angles: tilt angles from a three-axis sample.
// Depends on att_pkg, att_front, att_back.
//
// Input channel: in_valid_i/in_ready_o with accel_{x,y,z}_raw_i, one transaction
// per sample. Output channel: out_valid_o/out_ready_i with pitch_angle_o and
// roll_angle_o (1/128 degree), one transaction per sample, in order.
// The front register classifies and pre-rotates the sample; the back end is
// an unrolled pipeline of two CORDIC vectoring passes (min(CordicSteps,
// TableLen) stages each) with a gain-correction multiply of two stages between them.
// Each sample passes the front register and then every back-end stage in order.
// Throughput: one sample per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the back pipeline freezes
// and the front register holds one more sample; input ready then drops.
// Reset clears all valid flags; no results are pending after reset.
module accel_tilt_angles_core import att_pkg::*; #(
  parameter int CordicSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_raw_i,
  input  logic signed [15:0] accel_y_raw_i,
  input  logic signed [15:0] accel_z_raw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o
);
  logic f_valid, f_ready, f_allz, f_yz0;
  cordic_t f_c;
  logic signed [15:0] f_x;

  att_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .x_i(accel_x_raw_i), .y_i(accel_y_raw_i), .z_i(accel_z_raw_i),
    .f_valid_o(f_valid), .f_ready_i(f_ready), .f_c_o(f_c), .f_x_o(f_x),
    .f_allz_o(f_allz), .f_yz0_o(f_yz0)
  );

  att_back #(.Steps(CordicSteps)) u_back (
    .clk_i, .rst_ni, .f_valid_i(f_valid), .f_ready_o(f_ready), .f_c_i(f_c),
    .f_x_i(f_x), .f_allz_i(f_allz), .f_yz0_i(f_yz0),
    .out_valid_o, .out_ready_i, .pitch_o(pitch_angle_o), .roll_o(roll_angle_o)
  );
endmodule

/* tb/tb_accel_tilt_angles_core.sv */
// Testbench for accel_tilt_angles_core: drives raw accelerometer samples and
// checks pitch/roll against a bit-accurate CORDIC predictor. Depends on att_pkg.
`timescale 1ns / 1ps

class tilt_scoreboard;
  typedef struct {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } tilt_t;

  tilt_t pending_q[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned steps;

  function new(int unsigned n);
    steps = (n > att_pkg::TableLen) ? att_pkg::TableLen : n;
    errors = 0;
    checked = 0;
  endfunction

  function automatic longint atan_deg(int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
      1, 0};
    return tab[i];
  endfunction

  function automatic longint rotate_to_axis(longint x, longint y, ref longint ang);
    longint dx, dy;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += atan_deg(i);
      end else begin
        x -= dx; y += dy; ang -= atan_deg(i);
      end
    end
    return x;
  endfunction

  function automatic longint quantize(longint acc, longint lim);
    longint r;
    r = (acc + 256) >>> 9;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function void note_sample(shortint sx, shortint sy, shortint sz);
    longint ax, ay, az, px, py, mag, racc, pacc;
    tilt_t t;
    ax = longint'(sx) * 16384;
    ay = longint'(sy) * 16384;
    az = longint'(sz) * 16384;
    racc = 0;
    pacc = 0;
    if (ax == 0 && ay == 0 && az == 0) begin
      t.pitch = '0;
      t.roll = '0;
    end else begin
      if (ay == 0 && az == 0) begin
        mag = 0;
      end else begin
        px = az;
        py = ay;
        if (px < 0) begin
          if (py >= 0) begin
            px = ay; py = -az; racc = 90 * 65536;
          end else begin
            px = -ay; py = az; racc = -90 * 65536;
          end
        end
        mag = rotate_to_axis(px, py, racc);
        mag = (mag * 652032874 + (longint'(1) << 29)) >>> 30;
      end
      void'(rotate_to_axis(mag, ax, pacc));
      t.pitch = 15'(quantize(pacc, 11520));
      t.roll = 16'(quantize(racc, 23040));
    end
    pending_q.push_back(t);
  endfunction

  function void check_result(logic signed [14:0] pitch, logic signed [15:0] roll);
    tilt_t t;
    if (pending_q.size() == 0) begin
      $error("unexpected result pitch=%0d roll=%0d", pitch, roll);
      errors++;
      return;
    end
    t = pending_q.pop_front();
    checked++;
    if (pitch !== t.pitch) begin
      $error("pitch_angle: expected %0d, got %0d", t.pitch, pitch);
      errors++;
    end
    if (roll !== t.roll) begin
      $error("roll_angle: expected %0d, got %0d", t.roll, roll);
      errors++;
    end
  endfunction
endclass

module tb_accel_tilt_angles_core;
  import att_pkg::*;

  localparam int Steps = 16;
  localparam int Latency = 2 * Steps + 4;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] accel_x_raw_i = '0;
  logic signed [15:0] accel_y_raw_i = '0;
  logic signed [15:0] accel_z_raw_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] roll_angle_o;

  tilt_scoreboard sb = new(Steps);
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  bit timed_out = 1'b0;
  bit long_stall = 1'b0;

  accel_tilt_angles_core #(.CordicSteps(Steps)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return 16'(signed'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_valid_i <= 1'b1;
    accel_x_raw_i <= x;
    accel_y_raw_i <= y;
    accel_z_raw_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(x, y, z);
    sent++;
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(pitch_angle_o, roll_angle_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      out_ready_i <= long_stall ? 1'b0 :
                     ($urandom_range(0, 99) < 8) ? 1'b0 :
                     ($urandom_range(0, 99) < 25 ? 1'b0 : 1'b1);
    end
  end

  // long receiver stalls now and then
  initial begin
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk_i);
      long_stall <= 1'b1;
      repeat ($urandom_range(10, 60)) @(posedge clk_i);
      long_stall <= 1'b0;
    end
  end

  initial begin
    logic [15:0] dir_q[$][3];
    logic [15:0] v[3];
    dir_q = '{
      '{16'h0000, 16'h0000, 16'h0000}, '{16'h7fff, 16'h0000, 16'h0000},
      '{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h7fff},
      '{16'h0000, 16'h0000, 16'h8000}, '{16'h0000, 16'h7fff, 16'h0000},
      '{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h0001, 16'hffff},
      '{16'h0000, 16'hffff, 16'hffff}, '{16'h7fff, 16'h7fff, 16'h7fff},
      '{16'h8000, 16'h8000, 16'h8000}, '{16'h8000, 16'h7fff, 16'h8000},
      '{16'h7fff, 16'h8000, 16'h7fff}, '{16'h0001, 16'h0000, 16'h0000},
      '{16'hffff, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h0001},
      '{16'h0000, 16'h0000, 16'hffff}, '{16'h4000, 16'hc000, 16'h8000},
      '{16'h5555, 16'haaaa, 16'h5555}, '{16'h0000, 16'h1234, 16'hedcc}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_q[i]) send_sample(dir_q[i][0], dir_q[i][1], dir_q[i][2]);
    idle_input(1);
    for (int n = 0; n < 1350; n++) begin
      if (n == 600) begin
        idle_input(1);
        while (sb.pending_q.size() != 0) @(posedge clk_i);
      end
      foreach (v[k]) v[k] = rand_axis();
      send_sample(v[0], v[1], v[2]);
      if ((n / 100) % 3 != 1) idle_input(gap_len());
    end
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    $display("Covered %0d samples, %0d results checked, incl. axis extremes and zeros.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("** accel_tilt_angles_core: PASSED **");
    else $display("** accel_tilt_angles_core: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("** accel_tilt_angles_core: FAILED **");
      $finish;
    end
  end
endmodule

/* filelist.f */
rtl/core/att_pkg.sv
rtl/core/att_front.sv
rtl/core/att_back.sv
rtl/core/accel_tilt_angles_core.sv
tb/tb_accel_tilt_angles_core.sv
